// ===== design/dpf_pkg.sv =====
// Shared types and constants for the duplicate packet filter.
// Used by dpf_cell, duplicate_packet_filter_core and dpf_checker; depends on nothing.
`default_nettype none

package dpf_pkg;

   localparam int unsigned HISTORY_DEPTH_DEFAULT = 32;
   localparam int unsigned SIG_WIDTH             = 32;
   localparam int unsigned STAMP_WIDTH           = 32;
   localparam int unsigned AGE_WIDTH             = 16;
   localparam int unsigned VERDICT_WIDTH         = 2;

   localparam logic [AGE_WIDTH-1:0] MAX_AGE_RESET = 16'd60;

   localparam logic [VERDICT_WIDTH-1:0] VERDICT_NEW   = 2'd0;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_STALE = 2'd1;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_DUP   = 2'd2;

   // Update broadcast to every cell once the search result is known.
   typedef enum logic [1:0] {
      OP_NONE,
      OP_APPEND,
      OP_SHIFT_APPEND,
      OP_REMOVE
   } op_type;

   // One history entry, as handed from a cell to its left neighbor.
   typedef struct packed {
      logic                   valid;
      logic [SIG_WIDTH-1:0]   sig;
      logic [STAMP_WIDTH-1:0] stamp;
   } entry_type;

   // Search token that walks the row, one cell per cycle.
   typedef struct packed {
      logic                   active;
      logic                   hit;
      logic                   free_seen;
      logic [STAMP_WIDTH-1:0] hit_time;
   } token_type;

endpackage

`default_nettype wire

// ===== design/dpf_cell.sv =====
// One history cell of the duplicate packet filter: holds one entry and one
// stage of the search token. Depends on dpf_pkg.
`default_nettype none

module dpf_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [dpf_pkg::SIG_WIDTH-1:0]    key_i,
   input  logic [dpf_pkg::STAMP_WIDTH-1:0]  now_i,
   input  dpf_pkg::op_type                  op_i,
   input  dpf_pkg::token_type               tok_i,
   output dpf_pkg::token_type               tok_o,
   input  dpf_pkg::entry_type               right_i,
   output dpf_pkg::entry_type               entry_o
);

   import dpf_pkg::*;

   logic                   valid_ff;
   logic                   valid_in;
   logic [SIG_WIDTH-1:0]   sig_ff;
   logic [SIG_WIDTH-1:0]   sig_in;
   logic [STAMP_WIDTH-1:0] stamp_ff;
   logic [STAMP_WIDTH-1:0] stamp_in;
   token_type              tok_ff;
   token_type              tok_in;
   logic                   hit_here;
   logic                   first_free;
   logic                   load_right;
   logic                   load_new;

   // The token carries whether any cell to the left matched. Signatures are
   // unique in the history, so at most one cell ever raises a hit.
   always_comb begin
      hit_here = tok_i.active && valid_ff && (sig_ff == key_i) && !tok_i.hit;
      tok_in   = tok_ff;
      tok_in.active = tok_i.active;
      if (tok_i.active) begin
         tok_in.hit       = tok_i.hit | hit_here;
         tok_in.free_seen = tok_i.free_seen | !valid_ff;
         tok_in.hit_time  = hit_here ? stamp_ff : tok_i.hit_time;
      end
   end

   // The token fields hold after it passes, so they still describe this
   // cell's place relative to the match and the first free slot.
   always_comb begin
      first_free = tok_ff.free_seen && !tok_i.free_seen;
      load_right = 1'b0;
      load_new   = 1'b0;
      unique case (op_i)
         OP_NONE:         ;
         OP_APPEND:       load_new   = first_free;
         OP_SHIFT_APPEND: load_right = 1'b1;
         OP_REMOVE:       load_right = tok_ff.hit;
         default:         ;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      sig_in   = sig_ff;
      stamp_in = stamp_ff;
      if (load_right) begin
         valid_in = right_i.valid;
         sig_in   = right_i.sig;
         stamp_in = right_i.stamp;
      end else if (load_new) begin
         valid_in = 1'b1;
         sig_in   = key_i;
         stamp_in = now_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      sig_ff   <= sig_in;
      stamp_ff <= stamp_in;
   end

   always_comb begin
      tok_o         = tok_ff;
      entry_o.valid = valid_ff;
      entry_o.sig   = sig_ff;
      entry_o.stamp = stamp_ff;
   end

endmodule

`default_nettype wire

// ===== design/duplicate_packet_filter_core.sv =====
// Top level of the duplicate packet filter: control, age check and the row
// of history cells. Depends on dpf_pkg and dpf_cell.
`default_nettype none

// The filter keeps up to HISTORY_DEPTH packet signatures, oldest first, in a
// row of cells, each with the second it was stored. A word on the req side
// carries a signature and the current time; one word comes back on the rsp
// side with accepted and verdict (new and stored, stale repeat removed, or
// fresh duplicate rejected). A search token enters the first cell the cycle
// after a word is accepted and moves one cell per cycle, so the walk down the
// row sets the pace: the result is formed once the token leaves the last
// cell and the rsp side is free, and the next request is taken only once
// that result is formed. The history update is applied to all cells in the
// cycle after the result is formed, which overlaps the acceptance of the
// next word. One request is in flight at a time; a finished result sits in
// the output register and the next request is still accepted while it
// waits. The age limit register resets to 60 seconds and may only be
// written while no request is in flight.

module duplicate_packet_filter_core #(
   parameter int unsigned HISTORY_DEPTH = dpf_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dpf_pkg::SIG_WIDTH-1:0]       req_packet_signature,
   input  logic [dpf_pkg::STAMP_WIDTH-1:0]     req_now_seconds,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_accepted,
   output logic [dpf_pkg::VERDICT_WIDTH-1:0]   rsp_verdict,
   input  logic                                csr_write_enable,
   input  logic [dpf_pkg::AGE_WIDTH-1:0]       csr_write_data
);

   import dpf_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_HOLD
   } state_type;

   state_type                state_ff;
   state_type                state_in;
   logic                     start_ff;
   logic                     start_in;
   op_type                   op_ff;
   op_type                   op_in;
   logic [SIG_WIDTH-1:0]     key_ff;
   logic [SIG_WIDTH-1:0]     key_in;
   logic [STAMP_WIDTH-1:0]   now_ff;
   logic [STAMP_WIDTH-1:0]   now_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     rsp_accepted_ff;
   logic                     rsp_accepted_in;
   logic [VERDICT_WIDTH-1:0] rsp_verdict_ff;
   logic [VERDICT_WIDTH-1:0] rsp_verdict_in;
   logic [AGE_WIDTH-1:0]     max_age_ff;

   token_type                tok_chain [HISTORY_DEPTH+1];
   entry_type                shift_chain [HISTORY_DEPTH];
   token_type                tail;
   logic [STAMP_WIDTH-1:0]   age;
   logic                     stale;
   logic                     out_free;
   logic                     decide;

   // The first cell sees a fresh token with no match and no free slot yet.
   always_comb begin
      tok_chain[0].active    = start_ff;
      tok_chain[0].hit       = 1'b0;
      tok_chain[0].free_seen = 1'b0;
      tok_chain[0].hit_time  = '0;
   end

   // On a full history all cells shift down and the new entry enters at the
   // tail; on a removal the tail feeds an empty slot.
   always_comb begin
      shift_chain[HISTORY_DEPTH-1].valid = (op_ff == OP_SHIFT_APPEND);
      shift_chain[HISTORY_DEPTH-1].sig   = key_ff;
      shift_chain[HISTORY_DEPTH-1].stamp = now_ff;
   end

   for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_head
         dpf_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .key_i   (key_ff),
            .now_i   (now_ff),
            .op_i    (op_ff),
            .tok_i   (tok_chain[k]),
            .tok_o   (tok_chain[k+1]),
            .right_i (shift_chain[k]),
            .entry_o ()
         );
      end else begin : g_body
         dpf_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .key_i   (key_ff),
            .now_i   (now_ff),
            .op_i    (op_ff),
            .tok_i   (tok_chain[k]),
            .tok_o   (tok_chain[k+1]),
            .right_i (shift_chain[k]),
            .entry_o (shift_chain[k-1])
         );
      end
   end

   // The token leaving the last cell tells whether the signature was found,
   // its stored time, and whether any slot was free.
   always_comb begin
      tail     = tok_chain[HISTORY_DEPTH];
      age      = now_ff - tail.hit_time;
      stale    = age > {{(STAMP_WIDTH-AGE_WIDTH){1'b0}}, max_age_ff};
      out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in        = state_ff;
      start_in        = 1'b0;
      op_in           = OP_NONE;
      key_in          = key_ff;
      now_in          = now_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_verdict_in  = rsp_verdict_ff;
      decide          = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in   = req_packet_signature;
               now_in   = req_now_seconds;
               start_in = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (tail.active) begin
               if (out_free) begin
                  decide = 1'b1;
               end else begin
                  state_in = S_HOLD;
               end
            end
         end
         S_HOLD: begin
            decide = out_free;
         end
         default: state_in = S_IDLE;
      endcase

      if (decide) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
         if (!tail.hit) begin
            rsp_accepted_in = 1'b1;
            rsp_verdict_in  = VERDICT_NEW;
            op_in           = tail.free_seen ? OP_APPEND : OP_SHIFT_APPEND;
         end else if (stale) begin
            rsp_accepted_in = 1'b1;
            rsp_verdict_in  = VERDICT_STALE;
            op_in           = OP_REMOVE;
         end else begin
            rsp_accepted_in = 1'b0;
            rsp_verdict_in  = VERDICT_DUP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         op_ff        <= OP_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff          <= key_in;
      now_ff          <= now_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_verdict_ff  <= rsp_verdict_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff <= MAX_AGE_RESET;
      end else if (csr_write_enable) begin
         max_age_ff <= csr_write_data;
      end
   end

   // No request is taken while reset is held.
   assign req_ready    = (state_ff == S_IDLE) && !reset;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;
   assign rsp_verdict  = rsp_verdict_ff;

endmodule

`default_nettype wire

// ===== design/dpf_checker.sv =====
// Port-level assertions for duplicate_packet_filter_core and the bind that
// attaches them. Depends on dpf_pkg and duplicate_packet_filter_core.
`default_nettype none

module dpf_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_accepted,
   input  logic [dpf_pkg::VERDICT_WIDTH-1:0] rsp_verdict
);

   import dpf_pkg::*;

   // A waiting result word holds its contents until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict)
                                 && $stable(rsp_accepted))
      else $error("result word changed while stalled");

   // Only duplicates are rejected.
   a_accept_matches_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accepted == (rsp_verdict != VERDICT_DUP)))
      else $error("accepted flag disagrees with verdict");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict == VERDICT_NEW || rsp_verdict == VERDICT_STALE
                     || rsp_verdict == VERDICT_DUP))
      else $error("undefined verdict code");

   // One request at a time: after a request is taken the block is busy.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   // A new result appears exactly when the block returns to taking requests.
   a_result_frees_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result formed without freeing the request side");

endmodule

bind duplicate_packet_filter_core dpf_checker u_dpf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_accepted (rsp_accepted),
   .rsp_verdict  (rsp_verdict)
);

`default_nettype wire
